// ----- rtl/lirc_pkg.sv -----
// ----------------------------------------------------------------------------
// lirc_pkg
// Shared types, constants and the control program of the linear
// interpolation rate converter.
// ----------------------------------------------------------------------------
package lirc_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 10;
  localparam int POS_W    = 21;
  localparam int MN_W     = 2 * STEP_W;
  localparam int PROD_W   = 27;
  localparam int DIV_W    = 26;
  localparam int DCNT_W   = 5;
  localparam int PC_W     = 4;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_STEP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_STEP = 1'd1;

  localparam logic [STEP_W-1:0] INPUT_STEP_RST  = 10'd9;
  localparam logic [STEP_W-1:0] OUTPUT_STEP_RST = 10'd5;

  typedef logic [PC_W-1:0] pc_t;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_PRIME,
    OP_SHIFT,
    OP_WRAP,
    OP_ADVANCE,
    OP_MOD_LOAD,
    OP_DIV_STEP,
    OP_MUL,
    OP_QUO_LOAD,
    OP_EMIT
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_XFER,
    COND_PRIMING,
    COND_STOP,
    COND_DIV_MORE,
    COND_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_word_t;

  // Divider control
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  // Program addresses
  localparam pc_t STEP_WAIT    = 4'd0;
  localparam pc_t STEP_PRIME   = 4'd1;
  localparam pc_t STEP_SHIFT   = 4'd2;
  localparam pc_t STEP_WRAP    = 4'd3;
  localparam pc_t STEP_ADVANCE = 4'd4;
  localparam pc_t STEP_CHECK   = 4'd5;
  localparam pc_t STEP_MODLD   = 4'd6;
  localparam pc_t STEP_MODRUN  = 4'd7;
  localparam pc_t STEP_MUL     = 4'd8;
  localparam pc_t STEP_QUOLD   = 4'd9;
  localparam pc_t STEP_QUORUN  = 4'd10;
  localparam pc_t STEP_EMIT    = 4'd11;
  localparam pc_t STEP_LOOP    = 4'd12;

  // Control store: taken jump goes to target, otherwise fall through
  function automatic ctrl_word_t program_rom(input pc_t pc);
    ctrl_word_t cw;
    begin
      case (pc)
        STEP_WAIT:    cw = '{OP_ACCEPT,   COND_NO_XFER,     STEP_WAIT};
        STEP_PRIME:   cw = '{OP_PRIME,    COND_PRIMING,     STEP_WAIT};
        STEP_SHIFT:   cw = '{OP_SHIFT,    COND_NEVER,       STEP_WAIT};
        STEP_WRAP:    cw = '{OP_WRAP,     COND_NEVER,       STEP_WAIT};
        STEP_ADVANCE: cw = '{OP_ADVANCE,  COND_NEVER,       STEP_WAIT};
        STEP_CHECK:   cw = '{OP_NONE,     COND_STOP,        STEP_WAIT};
        STEP_MODLD:   cw = '{OP_MOD_LOAD, COND_NEVER,       STEP_WAIT};
        STEP_MODRUN:  cw = '{OP_DIV_STEP, COND_DIV_MORE,    STEP_MODRUN};
        STEP_MUL:     cw = '{OP_MUL,      COND_NEVER,       STEP_WAIT};
        STEP_QUOLD:   cw = '{OP_QUO_LOAD, COND_NEVER,       STEP_WAIT};
        STEP_QUORUN:  cw = '{OP_DIV_STEP, COND_DIV_MORE,    STEP_QUORUN};
        STEP_EMIT:    cw = '{OP_EMIT,     COND_OUT_BLOCKED, STEP_EMIT};
        STEP_LOOP:    cw = '{OP_NONE,     COND_ALWAYS,      STEP_CHECK};
        default:      cw = '{OP_NONE,     COND_ALWAYS,      STEP_WAIT};
      endcase
      return cw;
    end
  endfunction

endpackage

// ----- rtl/lirc_div.sv -----
// ----------------------------------------------------------------------------
// lirc_div
// Restoring unsigned divider by a 10-bit step, one quotient bit per cycle while stepped.
// ----------------------------------------------------------------------------
module lirc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  lirc_pkg::div_ctrl_t            ctrl,
  input  logic [lirc_pkg::DIV_W-1:0]     dividend,
  input  logic [lirc_pkg::STEP_W-1:0]    divisor,
  output logic [lirc_pkg::DIV_W-1:0]     quotient,
  output logic [lirc_pkg::STEP_W-1:0]    remainder,
  output logic                           more
);
  import lirc_pkg::*;

  logic [DIV_W-1:0]  dvd;
  logic [STEP_W-1:0] rem;
  logic [STEP_W-1:0] dsr;
  logic [DCNT_W-1:0] cnt;
  logic [STEP_W:0]   trial;
  logic              fits;

  // Trial subtract of the next partial remainder
  assign trial = {rem, dvd[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  // Load, then shift one quotient bit in per step
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= DCNT_W'(DIV_W);
    end else if (ctrl.step && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (ctrl.step) begin
      dvd <= {dvd[DIV_W-2:0], fits};
      rem <= fits ? STEP_W'(trial - {1'b0, dsr}) : trial[STEP_W-1:0];
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;
  assign more      = (cnt != DCNT_W'(1));

endmodule

// ----- rtl/linear_interp_rate_converter_unit.sv -----
// ----------------------------------------------------------------------------
// linear_interp_rate_converter_unit
// Rational rate converter with linear interpolation, one channel, run by a
// microcoded sequencer over a shared serial divider.
// ----------------------------------------------------------------------------
// A priming sample produces no output. A new input is accepted only once
// every output of the previous one is emitted, at most MAX_RUN per input;
// each output costs two passes of the bit-serial divider (position modulo
// step, then the interpolation quotient).
// Reset: clears sequencer, positions, samples and priming count, loads the
// step registers with 9 and 5; no clearing pass.
// ----------------------------------------------------------------------------
module linear_interp_rate_converter_unit #(
  parameter int MAX_RUN = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lirc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lirc_pkg::STEP_W-1:0]       cfg_data,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,   // [15:0] sample_in
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,   // [15:0] sample_out
  output logic                              m_axis_tlast,   // last_of_run
  output logic [0:0]                        m_axis_tuser    // [0] truncated
);
  import lirc_pkg::*;

  localparam int CNT_W = $clog2(MAX_RUN + 1);

  // Sequencer
  pc_t        pc;
  pc_t        pc_next;
  ctrl_word_t cw;
  logic       take;

  // Configuration and datapath registers
  logic [STEP_W-1:0]          input_step;
  logic [STEP_W-1:0]          output_step;
  logic [STEP_W-1:0]          m_step;
  logic [STEP_W-1:0]          n_step;
  logic [MN_W-1:0]            mn;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic signed [SAMPLE_W-1:0] cur_sample;
  logic [POS_W-1:0]           in_position;
  logic [POS_W-1:0]           out_position;
  logic [1:0]                 prime_count;
  logic [CNT_W-1:0]           count;
  logic signed [PROD_W-1:0]   prod;
  logic                       prod_neg;

  // Divider connection
  div_ctrl_t         div_ctrl;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  quo;
  logic [STEP_W-1:0] rem;
  logic              div_more;

  // Combinational helpers
  logic                     xfer_in;
  logic                     out_free;
  logic                     run_full;
  logic [POS_W-1:0]         out_adv;
  logic [POS_W-1:0]         in_wrapped;
  logic [POS_W-1:0]         out_wrapped;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]        quo_mag;
  logic signed [SAMPLE_W+1:0] quo_signed;
  logic signed [SAMPLE_W+1:0] interp;
  logic                     emit_last;
  logic                     emit_trunc;
  logic [PROD_W-1:0]        prod_mag;

  assign cw            = program_rom(pc);
  assign s_axis_tready = (cw.op == OP_ACCEPT);
  assign cfg_ready     = 1'b1;
  assign xfer_in       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign run_full      = (count == CNT_W'(MAX_RUN));

  // Evaluate jump condition and step the program counter
  always_comb begin
    case (cw.cond)
      COND_NEVER:       take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_NO_XFER:     take = !s_axis_tvalid;
      COND_PRIMING:     take = (prime_count != 2'd2);
      COND_STOP:        take = (out_position > in_position) || run_full;
      COND_DIV_MORE:    take = div_more;
      COND_OUT_BLOCKED: take = !out_free;
      default:          take = 1'b1;
    endcase
    pc_next = take ? cw.target : pc + 1'b1;
  end

  // Position arithmetic
  assign in_wrapped  = in_position - POS_W'(mn);
  assign out_wrapped = (out_position >= POS_W'(mn)) ? out_position - POS_W'(mn) : '0;
  assign out_adv     = out_position + POS_W'(m_step);

  // Interpolation arithmetic
  assign diff       = (SAMPLE_W+1)'(cur_sample) - (SAMPLE_W+1)'(prev_sample);
  assign prod_mag   = prod_neg ? PROD_W'(-prod) : PROD_W'(prod);
  assign quo_mag    = quo[SAMPLE_W:0];
  assign quo_signed = prod_neg ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});
  assign interp     = (SAMPLE_W+2)'(prev_sample) + quo_signed;
  assign emit_last  = (out_adv > in_position) || (count == CNT_W'(MAX_RUN - 1));
  assign emit_trunc = (out_adv <= in_position) && (count == CNT_W'(MAX_RUN - 1));

  // Drive the divider from the control word
  always_comb begin
    div_ctrl.load = (cw.op == OP_MOD_LOAD) || (cw.op == OP_QUO_LOAD);
    div_ctrl.step = (cw.op == OP_DIV_STEP);
    div_dividend  = (cw.op == OP_MOD_LOAD) ? DIV_W'(out_position) : prod_mag[DIV_W-1:0];
  end

  lirc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (div_dividend),
    .divisor   (n_step),
    .quotient  (quo),
    .remainder (rem),
    .more      (div_more)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      input_step  <= INPUT_STEP_RST;
      output_step <= OUTPUT_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INPUT_STEP:  input_step  <= cfg_data;
        REG_OUTPUT_STEP: output_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= STEP_WAIT;
      prime_count   <= '0;
      prev_sample   <= '0;
      cur_sample    <= '0;
      in_position   <= '0;
      out_position  <= '0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      pc <= pc_next;
      // Raise valid on an emitted output, drop it after the transfer
      if (cw.op == OP_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (cw.op)
        OP_PRIME: begin
          if (prime_count == 2'd0) begin
            prev_sample <= sample;
            prime_count <= 2'd1;
          end else if (prime_count == 2'd1) begin
            cur_sample  <= sample;
            prime_count <= 2'd2;
          end
        end
        OP_SHIFT: begin
          prev_sample <= cur_sample;
          cur_sample  <= sample;
        end
        OP_WRAP: begin
          count <= '0;
          if (in_position > POS_W'(mn)) begin
            in_position  <= in_wrapped;
            out_position <= out_wrapped;
          end
        end
        OP_ADVANCE: begin
          in_position <= in_position + POS_W'(n_step);
        end
        OP_EMIT: begin
          if (out_free) begin
            out_position  <= out_adv;
            count         <= count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_ACCEPT: begin
        if (xfer_in) begin
          sample <= s_axis_tdata;
          m_step <= (input_step == '0) ? STEP_W'(1) : input_step;
          n_step <= (output_step == '0) ? STEP_W'(1) : output_step;
        end
      end
      OP_SHIFT: begin
        mn <= m_step * n_step;
      end
      OP_MUL: begin
        prod     <= PROD_W'($signed({1'b0, rem})) * PROD_W'(diff);
        prod_neg <= diff[SAMPLE_W] && (rem != '0);
      end
      OP_EMIT: begin
        if (out_free) begin
          m_axis_tdata    <= interp[SAMPLE_W-1:0];
          m_axis_tlast    <= emit_last;
          m_axis_tuser[0] <= emit_trunc;
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_trunc_on_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("truncation flag on a non-final output");

  a_prime_range: assert property (@(posedge clk) disable iff (rst)
    prime_count != 2'd3)
    else $error("priming count out of range");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RUN))
    else $error("output run exceeded its limit");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    xfer_in |=> pc == STEP_PRIME)
    else $error("sequencer did not advance after input transfer");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_EMIT) && !out_free |=> pc == STEP_EMIT)
    else $error("sequencer left emit step while output blocked");

endmodule

// ----- tb/linear_interp_rate_converter_unit_test.sv -----
// ----------------------------------------------------------------------------
// linear_interp_rate_converter_unit_test
// Self-checking bench for the linear interpolation rate converter. A local
// predictor tracks the sample pair, both positions and the step registers.
// It queues the interpolated outputs of every accepted sample. A checker
// compares each output transfer against the oldest queued result while
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module linear_interp_rate_converter_unit_test;
  import lirc_pkg::*;

  localparam int RUN_LIMIT     = 64;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 700;
  localparam int CYCLE_LIMIT   = 20000000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                run_end;
    logic                cut_short;
  } interp_out_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_INPUT_STEP;
  logic [STEP_W-1:0]    cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata = '0;   // [15:0] sample_in
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;        // [15:0] sample_out
  logic                 m_axis_tlast;        // last_of_run
  logic [0:0]           m_axis_tuser;        // [0] truncated

  // Traffic shaping
  logic calm = 1'b0;
  logic out_hold = 1'b0;
  int   out_stall = 0;
  int   error_count = 0;
  int   cycle_count = 0;

  // Predictor copy of the converter state
  logic [STEP_W-1:0]          in_step_reg = INPUT_STEP_RST;
  logic [STEP_W-1:0]          out_step_reg = OUTPUT_STEP_RST;
  logic signed [SAMPLE_W-1:0] prev_s = '0;
  logic signed [SAMPLE_W-1:0] cur_s = '0;
  logic [POS_W-1:0]           in_pos = '0;
  logic [POS_W-1:0]           out_pos = '0;
  int                         prime_seen = 0;
  interp_out_t                awaited_samples[$];

  linear_interp_rate_converter_unit #(
    .MAX_RUN(RUN_LIMIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, a few long ones; none while calm
  function automatic int pick_gap();
    int r;
    begin
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
    end
  endfunction

  // Full-scale extremes, values near zero, otherwise any 16-bit pattern
  function automatic logic [15:0] pick_sample();
    int r;
    begin
      r = $urandom_range(0, 9);
      case (r)
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'(int'($urandom_range(0, 16)) - 8);
        default: return 16'($urandom);
      endcase
    end
  endfunction

  // Advance the predicted state by one sample and queue its outputs
  task automatic interpolate_run(input logic signed [SAMPLE_W-1:0] s);
    logic [POS_W-1:0] m;
    logic [POS_W-1:0] n;
    logic [POS_W-1:0] mn;
    int               emitted;
    int               frac;
    int               diff;
    int               value;
    interp_out_t      pending;
    begin
      // a zero step behaves as one
      m = in_step_reg;
      n = out_step_reg;
      if (m == '0) m = 1;
      if (n == '0) n = 1;
      mn = m * n;
      if (prime_seen == 0) begin
        prev_s = s;
        prime_seen = 1;
      end else if (prime_seen == 1) begin
        cur_s = s;
        prime_seen = 2;
      end else begin
        prev_s = cur_s;
        cur_s = s;
        // wrap both positions; an output position below the wrap clamps to zero
        if (in_pos > mn) begin
          in_pos = in_pos - mn;
          out_pos = (out_pos >= mn) ? out_pos - mn : '0;
        end
        in_pos = in_pos + n;
        emitted = 0;
        pending = '0;
        while (out_pos <= in_pos && emitted < RUN_LIMIT) begin
          if (emitted > 0) awaited_samples.push_back(pending);
          frac = int'(out_pos % n);
          diff = int'(cur_s) - int'(prev_s);
          value = int'(prev_s) + (frac * diff) / int'(n);
          pending = '{sample: value[SAMPLE_W-1:0], run_end: 1'b0, cut_short: 1'b0};
          out_pos = out_pos + m;
          emitted++;
        end
        // mark the end of the run and whether the limit cut it
        if (emitted > 0) begin
          pending.run_end = 1'b1;
          pending.cut_short = (out_pos <= in_pos);
          awaited_samples.push_back(pending);
        end
      end
    end
  endtask

  // Compare one output transfer against the oldest queued result
  task automatic check_output();
    interp_out_t want;
    interp_out_t got;
    begin
      got = '{sample: m_axis_tdata, run_end: m_axis_tlast, cut_short: m_axis_tuser[0]};
      if (awaited_samples.size() == 0) begin
        if (error_count < REPORT_LIMIT)
          $display("unexpected output: sample %0d last %0b truncated %0b",
                   $signed(got.sample), got.run_end, got.cut_short);
        error_count++;
      end else begin
        want = awaited_samples.pop_front();
        if (got !== want) begin
          if (error_count < REPORT_LIMIT)
            $display("mismatch: expected sample %0d last %0b truncated %0b, got %0d %0b %0b",
                     $signed(want.sample), want.run_end, want.cut_short,
                     $signed(got.sample), got.run_end, got.cut_short);
          error_count++;
        end
      end
    end
  endtask

  // Check output transfers; stall the output side at random or on hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_output();
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= pick_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !out_hold;
      end
    end
  end

  // Offer one sample after a random gap; hold valid high until the transfer
  task automatic send_sample(input logic [15:0] value);
    int gap;
    begin
      gap = pick_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= value;
      do @(posedge clk); while (!s_axis_tready);
      interpolate_run(value);
    end
  endtask

  // Drop valid, wait out every queued result, then let the block settle
  task automatic wait_idle();
    begin
      s_axis_tvalid <= 1'b0;
      while (awaited_samples.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  // Write both step registers back to back; only called while idle
  task automatic load_ratio(input logic [STEP_W-1:0] m_val, input logic [STEP_W-1:0] n_val);
    begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_INPUT_STEP;
      cfg_data <= m_val;
      do @(posedge clk); while (!cfg_ready);
      in_step_reg = m_val;
      cfg_index <= REG_OUTPUT_STEP;
      cfg_data <= n_val;
      do @(posedge clk); while (!cfg_ready);
      out_step_reg = n_val;
      cfg_valid <= 1'b0;
    end
  endtask

  // Priming pair, then full-scale swings at the reset ratio
  task automatic test_priming_defaults();
    begin
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h5555);
      send_sample(16'hAAAA);
      wait_idle();
    end
  endtask

  // Step extremes: zero steps, widest steps, run limit, rare outputs
  task automatic test_step_extremes();
    begin
      load_ratio('0, '0);
      repeat (3) send_sample(pick_sample());
      wait_idle();
      load_ratio('1, '1);
      repeat (2) send_sample(pick_sample());
      wait_idle();
      // far more outputs than the run limit allows; the output position clamps to zero at the wrap
      load_ratio(10'd1, '1);
      repeat (3) send_sample(pick_sample());
      wait_idle();
      load_ratio('1, '1);
      repeat (2) send_sample(pick_sample());
      wait_idle();
      load_ratio('1, 10'd1);
      repeat (4) send_sample(pick_sample());
      wait_idle();
      // pull the output position back close to the input position
      load_ratio(10'd32, '1);
      repeat (2) send_sample(pick_sample());
      wait_idle();
    end
  endtask

  // Hold the output side off while samples keep coming, so the input stalls
  task automatic test_output_hold_off();
    begin
      calm <= 1'b1;
      load_ratio(10'd3, 10'd7);
      fork
        begin
          out_hold <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          out_hold <= 1'b0;
        end
      join_none
      repeat (12) send_sample(pick_sample());
      wait_idle();
    end
  endtask

  // Random ratios with random samples; one phase runs without idling
  task automatic test_random_ratios();
    begin
      for (int phase = 0; phase < 8; phase++) begin
        calm <= (phase == 2);
        load_ratio(10'($urandom_range(0, 32)), 10'($urandom_range(0, 32)));
        repeat (48) send_sample(pick_sample());
        wait_idle();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_priming_defaults();
    test_step_extremes();
    test_output_hold_off();
    test_random_ratios();
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Abort a run that stops making progress
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
